// ----- rtl/urdf_pkg.sv -----
// shared types, constants and functions of the register datagram framer
`timescale 1ns / 1ps
package urdf_pkg;

  localparam int NUM_REGISTERS = 128;
  localparam int ADDR_W        = 7;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_INIT   = 8'h00;

  localparam logic [1:0] ACC_NONE = 2'b00;
  localparam logic [1:0] ACC_RD   = 2'b01;
  localparam logic [1:0] ACC_WR   = 2'b10;
  localparam logic [1:0] ACC_RW   = 2'b11;

  localparam int ACC_RD_BIT = 0;
  localparam int ACC_WR_BIT = 1;

  localparam logic [2:0] IDX_SYNC   = 3'd0;
  localparam logic [2:0] IDX_NODE   = 3'd1;
  localparam logic [2:0] IDX_ADDR   = 3'd2;
  localparam logic [2:0] IDX_VAL3   = 3'd3;
  localparam logic [2:0] IDX_VAL2   = 3'd4;
  localparam logic [2:0] IDX_VAL1   = 3'd5;
  localparam logic [2:0] IDX_VAL0   = 3'd6;
  localparam logic [2:0] IDX_RD_CRC = 3'd3;
  localparam logic [2:0] IDX_WR_CRC = 3'd7;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       value;
  } req_t;

  typedef struct packed {
    logic       busy;
    logic       is_write;
    logic [2:0] idx;
  } back_status_t;

  function automatic logic [1:0] access_lookup(input logic [ADDR_W-1:0] addr);
    logic [1:0] acc;
    unique case (addr) inside
      7'd0, 7'd1, 7'd7, 7'd108, 7'd112:                   acc = ACC_RW;
      7'd2, 7'd5, 7'd6, 7'd18, 7'd106, 7'd107, 7'd111,
      7'd113, 7'd114:                                     acc = ACC_RD;
      7'd3, 7'd4, 7'd16, 7'd17, 7'd19, 7'd34:             acc = ACC_WR;
      default:                                            acc = ACC_NONE;
    endcase
    return acc;
  endfunction

  // crc8 over one byte, bits taken lsb first
  function automatic logic [7:0] crc_update(input logic [7:0] crc_in,
                                            input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[7] ^ data[k];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/urdf_front.sv -----
// request intake stage: address range and access check
`timescale 1ns / 1ps
module urdf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_func,
  input  logic [7:0]    in_reg_address,
  input  logic [31:0]   in_write_value,
  output logic          req_push,
  output urdf_pkg::req_t req_data,
  input  logic          req_full
);
  import urdf_pkg::*;

  logic       valid_r, valid_nxt;
  req_t       req_r, req_nxt;
  logic       load;
  logic       allowed;
  logic [1:0] acc;

  assign acc      = access_lookup(in_reg_address[ADDR_W-1:0]);
  assign allowed  = (in_reg_address < 8'(NUM_REGISTERS)) &&
                    (in_func ? acc[ACC_WR_BIT] : acc[ACC_RD_BIT]);
  assign in_full  = valid_r && req_full;
  assign load     = in_push && !in_full;
  assign req_push = valid_r && !req_full;
  assign req_data = req_r;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (load) begin
      valid_nxt = allowed;
      req_nxt   = '{is_write: in_func, addr: in_reg_address[ADDR_W-1:0],
                    value: in_write_value};
    end else if (req_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

endmodule

// ----- rtl/urdf_fifo.sv -----
// short request queue between intake and byte sequencer
`timescale 1ns / 1ps
module urdf_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  urdf_pkg::req_t               push_data,
  output logic                         full,
  input  logic                         pop,
  output urdf_pkg::req_t               pop_data,
  output logic                         empty,
  output logic [urdf_pkg::FIFO_CW-1:0] count
);
  import urdf_pkg::*;

  req_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/urdf_back.sv -----
// byte sequencer with running crc8 and output register
`timescale 1ns / 1ps
module urdf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            node_address,
  input  logic                  req_empty,
  input  urdf_pkg::req_t        req_data,
  output logic                  req_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last_byte,
  output urdf_pkg::back_status_t status
);
  import urdf_pkg::*;

  logic       busy_r, busy_nxt;
  req_t       req_r, req_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       adv, is_last, load;
  logic [7:0] body_byte, cur_byte;

  assign adv     = busy_r && (!out_valid_r || out_pop);
  assign is_last = (idx_r == (req_r.is_write ? IDX_WR_CRC : IDX_RD_CRC));
  assign load    = !req_empty && (!busy_r || (adv && is_last));
  assign req_pop = load;

  always_comb begin
    case (idx_r)
      IDX_SYNC: body_byte = SYNC_BYTE;
      IDX_NODE: body_byte = node_address;
      IDX_ADDR: body_byte = {req_r.is_write, req_r.addr};
      IDX_VAL3: body_byte = req_r.value[31:24];
      IDX_VAL2: body_byte = req_r.value[23:16];
      IDX_VAL1: body_byte = req_r.value[15:8];
      IDX_VAL0: body_byte = req_r.value[7:0];
      default:  body_byte = crc_r;
    endcase
  end

  assign cur_byte = is_last ? crc_r : body_byte;

  always_comb begin
    busy_nxt      = busy_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      idx_nxt = idx_r + 1'b1;
      crc_nxt = crc_update(crc_r, cur_byte);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = is_last;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      req_nxt  = req_data;
      idx_nxt  = IDX_SYNC;
      crc_nxt  = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= IDX_SYNC;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    req_r      <= req_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty     = !out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;
  assign status        = '{busy: busy_r, is_write: req_r.is_write, idx: idx_r};

endmodule

// ----- rtl/uart_register_datagram_framer_top.sv -----
// top level of the uart register datagram framer
//
// input queue side: a request word (func, reg_address, write_value) is taken
// when in_push is high and in_full is low. requests with an out-of-range
// address or without the needed access bit are dropped and give no bytes.
// output queue side: datagram bytes appear while out_empty is low and leave
// on out_pop; out_last_byte marks the closing crc byte.
// cfg side: cfg_data is the node address, written on cfg_valid (always ready).
// throughput: one datagram byte per cycle from the byte sequencer while the
// receiver keeps popping; a write datagram has 8 bytes, a read 4.
// the intake takes a word every cycle while the two-entry queue has room.
// a request goes from the intake register via the queue to the sequencer.
// when the receiver stalls the output register holds, the sequencer stops,
// then the queue and the intake fill and in_full rises.
// reset: output empty, queue cleared, node address 0.
`timescale 1ns / 1ps
module uart_register_datagram_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_reg_address,
  input  logic [31:0] in_write_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import urdf_pkg::*;

  logic [7:0]         node_r, node_nxt;
  logic               req_push, req_full, req_pop, req_empty;
  req_t               push_data, pop_data;
  logic [FIFO_CW-1:0] fifo_count;
  back_status_t       status;

  assign cfg_ready = 1'b1;

  always_comb begin
    node_nxt = node_r;
    if (cfg_valid && cfg_ready) begin
      node_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
    end else begin
      node_r <= node_nxt;
    end
  end

  urdf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_reg_address (in_reg_address),
    .in_write_value (in_write_value),
    .req_push       (req_push),
    .req_data       (push_data),
    .req_full       (req_full)
  );

  urdf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (push_data),
    .full      (req_full),
    .pop       (req_pop),
    .pop_data  (pop_data),
    .empty     (req_empty),
    .count     (fifo_count)
  );

  urdf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .node_address  (node_r),
    .req_empty     (req_empty),
    .req_data      (pop_data),
    .req_pop       (req_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte),
    .status        (status)
  );

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("request queue count above depth");

  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    (status.busy && !status.is_write) |-> (status.idx <= IDX_RD_CRC))
    else $error("read datagram ran past its crc byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_intake_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (fifo_count == FIFO_CW'(FIFO_DEPTH)))
    else $error("intake stalled while queue has room");
`endif

endmodule

// ----- tb/datagram_checker.sv -----
// checker for the register datagram framer: predicts datagram bytes and compares them
`timescale 1ns / 1ps
module datagram_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_reg_address,
  input  logic [31:0] in_write_value,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          bytes_outstanding,
  output int          error_count
);

  localparam int          REG_COUNT   = 128;
  localparam logic [7:0]  SYNC_WORD   = 8'h05;
  localparam logic [7:0]  WRITE_FLAG  = 8'h80;
  localparam logic [7:0]  CRC_GEN     = 8'h07;
  // one bit per register address
  localparam logic [127:0] READABLE_MAP = 128'h0007_9c00_0000_0000_0000_0000_0004_00e7;
  localparam logic [127:0] WRITABLE_MAP = 128'h0001_1000_0000_0000_0000_0004_000b_009b;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [7:0]  node_addr = 8'h00;

  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc;
    for (int b = 0; b < 8; b++) begin
      if (r[7] != data[b]) begin
        r = {r[6:0], 1'b0} ^ CRC_GEN;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic frame_request(input logic is_write, input logic [7:0] addr,
                               input logic [31:0] value);
    logic [7:0]  frame [8];
    logic [7:0]  crc;
    int          len;
    frame_byte_t fb;
    if (addr >= REG_COUNT) begin
      return;
    end
    if (is_write ? !WRITABLE_MAP[addr[6:0]] : !READABLE_MAP[addr[6:0]]) begin
      return;
    end
    frame[0] = SYNC_WORD;
    frame[1] = node_addr;
    if (is_write) begin
      frame[2] = addr | WRITE_FLAG;
      frame[3] = value[31:24];
      frame[4] = value[23:16];
      frame[5] = value[15:8];
      frame[6] = value[7:0];
      len = 8;
    end else begin
      frame[2] = addr;
      len = 4;
    end
    crc = 8'h00;
    for (int i = 0; i < len - 1; i++) begin
      crc = crc8_lsb_first(crc, frame[i]);
    end
    frame[len - 1] = crc;
    for (int i = 0; i < len; i++) begin
      fb.data = frame[i];
      fb.last = (i == len - 1);
      expected_bytes.push_back(fb);
    end
  endtask

  task automatic report_error(input string what, input frame_byte_t want);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime,
               what, want.data, want.last, out_tx_byte, out_last_byte);
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      node_addr = 8'h00;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          want = '0;
          report_error("unexpected word", want);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_tx_byte || want.last !== out_last_byte) begin
            report_error("mismatch", want);
          end
        end
      end
      if (in_push && !in_full) begin
        frame_request(in_func, in_reg_address, in_write_value);
      end
      if (cfg_valid && cfg_ready) begin
        node_addr = cfg_data;
      end
    end
    bytes_outstanding = expected_bytes.size();
  end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the register datagram framer: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module testbench;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam int PHASE_ITEMS = 75;
  localparam int PHASES      = 6;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 150;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_func = 1'b0;
  logic [7:0]  in_reg_address = 8'h00;
  logic [31:0] in_write_value = 32'h0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  int bytes_outstanding;
  int error_count;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int pop_style = 0;
  int style_left = 0;
  int quiet_cycles = 0;

  uart_register_datagram_framer_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_reg_address (in_reg_address),
    .in_write_value (in_write_value),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tx_byte    (out_tx_byte),
    .out_last_byte  (out_last_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  datagram_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_reg_address    (in_reg_address),
    .in_write_value    (in_write_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_tx_byte       (out_tx_byte),
    .out_last_byte     (out_last_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .bytes_outstanding (bytes_outstanding),
    .error_count       (error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random pop styles, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      out_pop       <= 1'b0;
      hold_left     <= LONG_HOLD;
      holds_granted <= holds_granted + 1;
    end else begin
      if (style_left == 0) begin
        pop_style  <= int'($urandom_range(0, 3));
        style_left <= int'($urandom_range(16, 96));
      end else begin
        style_left <= style_left - 1;
      end
      case (pop_style)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 1) != 0);
        2: out_pop <= ($urandom_range(0, 7) != 0);
        default: out_pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic offer_request(input logic func, input logic [7:0] addr,
                               input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 16));
    end
    burst_left--;
    in_push        <= 1'b1;
    in_func        <= func;
    in_reg_address <= addr;
    in_write_value <= value;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain_outputs();
    in_push <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_address(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers with some access, plus a couple with none
  function automatic logic [7:0] listed_register();
    case ($urandom_range(0, 21))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd3;
      4: return 8'd4;
      5: return 8'd5;
      6: return 8'd6;
      7: return 8'd7;
      8: return 8'd16;
      9: return 8'd17;
      10: return 8'd18;
      11: return 8'd19;
      12: return 8'd34;
      13: return 8'd106;
      14: return 8'd107;
      15: return 8'd108;
      16: return 8'd111;
      17: return 8'd112;
      18: return 8'd113;
      19: return 8'd114;
      20: return 8'd8;
      default: return 8'd127;
    endcase
  endfunction

  task automatic offer_random();
    logic       func;
    logic [7:0] addr;
    int         pick;
    func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
    pick = int'($urandom_range(0, 99));
    if (pick < 80) begin
      addr = listed_register();
    end else if (pick < 90) begin
      addr = 8'($urandom_range(0, 127));
    end else begin
      addr = 8'($urandom_range(128, 255));
    end
    offer_request(func, addr, $urandom());
  endtask

  initial begin
    logic [7:0] node_value;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    offer_request(FUNC_READ,  8'd0,   32'h0);
    offer_request(FUNC_WRITE, 8'd0,   32'h0000_0000);
    offer_request(FUNC_WRITE, 8'd0,   32'hffff_ffff);
    offer_request(FUNC_WRITE, 8'd7,   32'h8000_0001);
    offer_request(FUNC_READ,  8'd2,   32'hffff_ffff);
    offer_request(FUNC_WRITE, 8'd2,   32'h1234_5678);
    offer_request(FUNC_READ,  8'd3,   32'h0);
    offer_request(FUNC_WRITE, 8'd3,   32'h1234_5678);
    offer_request(FUNC_READ,  8'd127, 32'h0);
    offer_request(FUNC_WRITE, 8'd127, 32'hffff_ffff);
    offer_request(FUNC_READ,  8'd128, 32'h0);
    offer_request(FUNC_WRITE, 8'd255, 32'hffff_ffff);
    offer_request(FUNC_READ,  8'd255, 32'h0);
    offer_request(FUNC_READ,  8'd114, 32'h0);
    offer_request(FUNC_WRITE, 8'd112, 32'ha5a5_5a5a);
    offer_request(FUNC_WRITE, 8'd34,  32'h00ff_00ff);
    offer_request(FUNC_READ,  8'd18,  32'h0);
    offer_request(FUNC_WRITE, 8'd19,  32'h7fff_fffe);
    offer_request(FUNC_READ,  8'd8,   32'h0);
    offer_request(FUNC_WRITE, 8'd108, 32'hdead_beef);
    offer_request(FUNC_READ,  8'd108, 32'h0);
    drain_outputs();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: node_value = 8'hff;
        1: node_value = 8'h00;
        4: node_value = 8'h80;
        5: node_value = 8'h7f;
        default: node_value = 8'($urandom_range(0, 255));
      endcase
      write_node_address(node_value);
      gaps_on = (ph != 3);
      if (ph == 2) begin
        holds_asked++;
      end
      repeat (PHASE_ITEMS) offer_random();
      drain_outputs();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
